// ===== design/ihcp_pkg.sv =====
package ihcp_pkg;

	localparam int FixedLen = 40;
	localparam int LenShift = 3;
	localparam int PosW = 17;
	localparam int PosMax = (1 << PosW) - 1;
	localparam int QueueDepthDefault = 2;

	localparam logic [7:0] NH_HOPOPT   = 8'd0;
	localparam logic [7:0] NH_ROUTING  = 8'd43;
	localparam logic [7:0] NH_ESP      = 8'd50;
	localparam logic [7:0] NH_AH       = 8'd51;
	localparam logic [7:0] NH_DSTOPT   = 8'd60;
	localparam logic [7:0] NH_MOBILITY = 8'd135;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_TRUNC = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_LEN_HI,
		CLS_LEN_LO,
		CLS_NEXT,
		CLS_HOP,
		CLS_SRC,
		CLS_DST,
		CLS_EXT
	} cls_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} request_t;

	typedef struct packed {
		logic [7:0]  upper_protocol;
		logic [63:0] source_high;
		logic [63:0] source_low;
		logic [63:0] dest_high;
		logic [63:0] dest_low;
		logic [7:0]  hop_limit;
		logic [16:0] header_bytes;
		logic [15:0] upper_payload_len;
		logic [1:0]  parse_status;
	} result_t;

	typedef struct packed {
		logic [7:0]      data;
		logic            last;
		cls_t            cls;
		logic            half;
		logic [PosW-1:0] pos;
	} item_t;

	function automatic logic is_ext(input logic [7:0] code);
		logic r;
		case (code) inside
			NH_HOPOPT, NH_ROUTING, NH_ESP, NH_AH, NH_DSTOPT, NH_MOBILITY: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/ihcp_front.sv =====
module ihcp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ihcp_pkg::request_t  request,
	input  logic                q_full,
	output logic                q_push,
	output ihcp_pkg::item_t     q_item
);

	localparam int PosW = ihcp_pkg::PosW;

	logic [PosW-1:0] pos_q;
	logic            accept;

	assign accept = push && !q_full;
	assign q_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (request.last_byte) begin
				pos_q <= '0;
			end else if (pos_q != PosW'(ihcp_pkg::PosMax)) begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

	// tag each byte with the header field it lands in
	always_comb begin
		q_item.data = request.data_byte;
		q_item.last = request.last_byte;
		q_item.pos  = pos_q;
		q_item.half = 1'b0;
		if (pos_q == PosW'(4)) begin
			q_item.cls = ihcp_pkg::CLS_LEN_HI;
		end else if (pos_q == PosW'(5)) begin
			q_item.cls = ihcp_pkg::CLS_LEN_LO;
		end else if (pos_q == PosW'(6)) begin
			q_item.cls = ihcp_pkg::CLS_NEXT;
		end else if (pos_q == PosW'(7)) begin
			q_item.cls = ihcp_pkg::CLS_HOP;
		end else if (pos_q >= PosW'(8) && pos_q < PosW'(24)) begin
			q_item.cls  = ihcp_pkg::CLS_SRC;
			q_item.half = pos_q >= PosW'(16);
		end else if (pos_q >= PosW'(24) && pos_q < PosW'(ihcp_pkg::FixedLen)) begin
			q_item.cls  = ihcp_pkg::CLS_DST;
			q_item.half = pos_q >= PosW'(32);
		end else if (pos_q >= PosW'(ihcp_pkg::FixedLen)) begin
			q_item.cls = ihcp_pkg::CLS_EXT;
		end else begin
			q_item.cls = ihcp_pkg::CLS_NONE;
		end
	end

endmodule

// ===== design/ihcp_fifo.sv =====
module ihcp_fifo #(
	parameter int Depth = ihcp_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  ihcp_pkg::item_t  wr_item,
	output logic             full,
	input  logic             rd_en,
	output logic             rd_valid,
	output ihcp_pkg::item_t  rd_item
);

	localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	ihcp_pkg::item_t mem_q [Depth];
	logic [IdxW-1:0] wr_idx_q, rd_idx_q;
	logic [CntW-1:0] count_q;
	logic            do_wr, do_rd;

	assign full     = count_q == CntW'(Depth);
	assign rd_valid = count_q != '0;
	assign rd_item  = mem_q[rd_idx_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_idx_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_idx_q <= (wr_idx_q == IdxW'(Depth - 1)) ? '0 : wr_idx_q + IdxW'(1);
			end
			if (do_rd) begin
				rd_idx_q <= (rd_idx_q == IdxW'(Depth - 1)) ? '0 : rd_idx_q + IdxW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ===== design/ihcp_back.sv =====
module ihcp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  ihcp_pkg::item_t    q_item,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output ihcp_pkg::result_t  result
);

	localparam int PosW = ihcp_pkg::PosW;
	localparam logic [PosW-1:0] Fixed = PosW'(ihcp_pkg::FixedLen);

	logic [PosW-1:0] decl_q, nes_q, hend_q;
	logic [7:0]      code_q, hop_q;
	logic            done_q;
	logic [63:0]     src_q [2];
	logic [63:0]     dst_q [2];

	logic [PosW-1:0] n_decl, n_nes, n_hend, captured, ext_len;
	logic [7:0]      n_code, n_hop;
	logic            n_done;
	logic [63:0]     n_src [2];
	logic [63:0]     n_dst [2];
	ihcp_pkg::status_t status;
	ihcp_pkg::result_t summary;
	logic            out_valid_q;
	logic            take;

	// only a last byte has to wait for the held summary to leave
	assign take  = q_valid && (!q_item.last || !out_valid_q || pop);
	assign q_pop = take;
	assign empty = !out_valid_q;

	assign ext_len = ({9'b0, q_item.data} + PosW'(1)) << ihcp_pkg::LenShift;

	always_comb begin
		n_decl = decl_q;
		n_nes  = nes_q;
		n_hend = hend_q;
		n_code = code_q;
		n_hop  = hop_q;
		n_done = done_q;
		n_src  = src_q;
		n_dst  = dst_q;
		unique case (q_item.cls)
			ihcp_pkg::CLS_LEN_HI: n_decl = Fixed + {1'b0, q_item.data, 8'h00};
			ihcp_pkg::CLS_LEN_LO: n_decl = decl_q + {9'b0, q_item.data};
			ihcp_pkg::CLS_NEXT: begin
				n_code = q_item.data;
				n_done = !ihcp_pkg::is_ext(q_item.data);
			end
			ihcp_pkg::CLS_HOP: n_hop = q_item.data;
			ihcp_pkg::CLS_SRC:
				n_src[q_item.half] = {src_q[q_item.half][55:0], q_item.data};
			ihcp_pkg::CLS_DST:
				n_dst[q_item.half] = {dst_q[q_item.half][55:0], q_item.data};
			ihcp_pkg::CLS_EXT: begin
				// walk the chain only inside the declared length
				if (q_item.pos < decl_q && !done_q) begin
					if (q_item.pos == nes_q) begin
						n_code = q_item.data;
					end else if ({1'b0, q_item.pos} == {1'b0, nes_q} + (PosW + 1)'(1)) begin
						n_hend = nes_q + ext_len;
						n_nes  = nes_q + ext_len;
						n_done = !ihcp_pkg::is_ext(code_q);
					end
				end
			end
			ihcp_pkg::CLS_NONE: ;
			default: ;
		endcase
	end

	always_comb begin
		captured = (q_item.pos == PosW'(ihcp_pkg::PosMax)) ? q_item.pos
			: q_item.pos + PosW'(1);
		if (captured < Fixed || captured < n_decl) begin
			status = ihcp_pkg::ST_SHORT;
		end else if (!n_done || n_hend > n_decl) begin
			status = ihcp_pkg::ST_TRUNC;
		end else begin
			status = ihcp_pkg::ST_OK;
		end
		summary.upper_protocol    = n_code;
		summary.source_high       = n_src[0];
		summary.source_low        = n_src[1];
		summary.dest_high         = n_dst[0];
		summary.dest_low          = n_dst[1];
		summary.hop_limit         = n_hop;
		summary.header_bytes      = n_hend;
		summary.upper_payload_len = (status == ihcp_pkg::ST_OK) ? 16'(n_decl - n_hend) : 16'h0;
		summary.parse_status      = status;
	end

	always_ff @(posedge clk) begin
		if (take && q_item.last) begin
			result <= summary;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q      <= '0;
			nes_q       <= Fixed;
			hend_q      <= Fixed;
			code_q      <= '0;
			hop_q       <= '0;
			done_q      <= 1'b0;
			src_q       <= '{default: '0};
			dst_q       <= '{default: '0};
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (q_item.last) begin
					// drop packet state once the summary is out
					decl_q <= '0;
					nes_q  <= Fixed;
					hend_q <= Fixed;
					code_q <= '0;
					hop_q  <= '0;
					done_q <= 1'b0;
					src_q  <= '{default: '0};
					dst_q  <= '{default: '0};
				end else begin
					decl_q <= n_decl;
					nes_q  <= n_nes;
					hend_q <= n_hend;
					code_q <= n_code;
					hop_q  <= n_hop;
					done_q <= n_done;
					src_q  <= n_src;
					dst_q  <= n_dst;
				end
			end
			if (take && q_item.last) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/ipv6_header_chain_parser_top.sv =====
// IPv6 header chain parser.
// Request channel: one packet byte per request, starting at the first byte of
// the fixed header; push is taken at a clock edge where full is low. Mark the
// final captured byte with last_byte.
// Result channel: one summary per packet (addresses, hop limit, protocol where
// the next-header walk stopped, header bytes, upper payload length, status).
// It sits on result while empty is low and leaves on an edge with pop high.
// Throughput: one byte per clock while full stays low. The last byte of a
// packet passes through the queue and then the result register before its
// summary appears on result.
// A short queue sits between the byte classifier and the chain walker, so a
// stalled result keeps bytes flowing until the queue fills; then full rises.
// The walker holds one finished summary and keeps taking bytes of the next
// packet until that packet's last byte, which waits for pop.
// Reset (arst_n low) empties the queue, drops any waiting summary and returns
// the parser to the start of a packet.
module ipv6_header_chain_parser_top #(
	parameter int QueueDepth = ihcp_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  ihcp_pkg::request_t request,
	output logic               empty,
	input  logic               pop,
	output ihcp_pkg::result_t  result
);

	ihcp_pkg::item_t wr_item, rd_item;
	logic            q_push, q_pop, q_valid;

	ihcp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.request(request),
		.q_full (full),
		.q_push (q_push),
		.q_item (wr_item)
	);

	ihcp_fifo #(
		.Depth(QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_item (wr_item),
		.full    (full),
		.rd_en   (q_pop),
		.rd_valid(q_valid),
		.rd_item (rd_item)
	);

	ihcp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_item (rd_item),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== tb/sv/ipv6_header_chain_parser_top_tb.sv =====
module ipv6_header_chain_parser_top_tb;
	import ihcp_pkg::*;

	localparam logic [7:0] NH_TCP      = 8'd6;
	localparam logic [7:0] NH_UDP      = 8'd17;
	localparam logic [7:0] NH_FRAGMENT = 8'd44;
	localparam logic [7:0] NH_NO_NEXT  = 8'd59;

	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZEROS  = 1;
	localparam int FILL_ONES   = 2;

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_PRINTED  = 30;
	localparam int RANDOM_BYTES = 780;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     full;
	request_t request = '0;
	logic     empty;
	logic     pop = 1'b0;
	result_t  result;

	ipv6_header_chain_parser_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// parser state, kept alongside the block
	int unsigned  pos_cnt;
	int unsigned  total_len;
	logic [7:0]   walk_code;
	int unsigned  ext_start;
	bit           walk_stop;
	int unsigned  ext_end;
	logic [63:0]  src_word [2];
	logic [63:0]  dst_word [2];
	logic [7:0]   hop_val;

	result_t      pending_summaries [$];
	logic [7:0]   pkt [$];

	int errors;
	int n_bytes;
	int n_packets;
	int n_checked;
	int n_status [3];
	int burst_left;
	bit gaps_on = 1'b1;
	int hold_req;
	int hold_left;
	int seg_kind;
	int seg_left;
	int idle_cycles;

	function automatic bit chains_on(input logic [7:0] code);
		return code == NH_HOPOPT || code == NH_ROUTING || code == NH_ESP ||
			code == NH_AH || code == NH_DSTOPT || code == NH_MOBILITY;
	endfunction

	function automatic void clear_parser();
		pos_cnt = 0;
		total_len = 0;
		walk_code = 8'd0;
		ext_start = FixedLen;
		walk_stop = 1'b0;
		ext_end = FixedLen;
		src_word[0] = '0;
		src_word[1] = '0;
		dst_word[0] = '0;
		dst_word[1] = '0;
		hop_val = 8'd0;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, input logic lst,
			output result_t s);
		int unsigned p;
		int unsigned k;
		status_t st;
		p = pos_cnt;
		s = '0;
		if (p == 4) begin
			total_len = FixedLen + (int'(b) << 8);
		end else if (p == 5) begin
			total_len = (total_len + b) & PosMax;
		end else if (p == 6) begin
			walk_code = b;
			walk_stop = !chains_on(b);
		end else if (p == 7) begin
			hop_val = b;
		end else if (p >= 8 && p < 24) begin
			k = (p - 8) >> 3;
			src_word[k] = {src_word[k][55:0], b};
		end else if (p >= 24 && p < FixedLen) begin
			k = (p - 24) >> 3;
			dst_word[k] = {dst_word[k][55:0], b};
		end else if (p >= FixedLen && p < total_len && !walk_stop) begin
			if (p == ext_start) begin
				walk_code = b;
			end else if (p == ext_start + 1) begin
				ext_end = (ext_start + ((int'(b) + 1) << LenShift)) & PosMax;
				ext_start = ext_end;
				walk_stop = !chains_on(walk_code);
			end
		end
		if (pos_cnt < PosMax)
			pos_cnt++;
		if (!lst)
			return 1'b0;
		if (pos_cnt < FixedLen || pos_cnt < total_len)
			st = ST_SHORT;
		else if (!walk_stop || ext_end > total_len)
			st = ST_TRUNC;
		else
			st = ST_OK;
		s.upper_protocol = walk_code;
		s.source_high = src_word[0];
		s.source_low = src_word[1];
		s.dest_high = dst_word[0];
		s.dest_low = dst_word[1];
		s.hop_limit = hop_val;
		s.header_bytes = ext_end[16:0];
		s.upper_payload_len = (st == ST_OK) ? 16'(total_len - ext_end) : 16'd0;
		s.parse_status = st;
		clear_parser();
		return 1'b1;
	endfunction

	task automatic report_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_error($sformatf("summary %0d %s: got %h, expected %h",
				n_checked, name, got, want));
	endtask

	task automatic check_summary(input result_t got);
		result_t want;
		if (pending_summaries.size() == 0) begin
			report_error("summary popped with none outstanding");
			return;
		end
		want = pending_summaries.pop_front();
		compare_field("upper_protocol", got.upper_protocol, want.upper_protocol);
		compare_field("source_high", got.source_high, want.source_high);
		compare_field("source_low", got.source_low, want.source_low);
		compare_field("dest_high", got.dest_high, want.dest_high);
		compare_field("dest_low", got.dest_low, want.dest_low);
		compare_field("hop_limit", got.hop_limit, want.hop_limit);
		compare_field("header_bytes", got.header_bytes, want.header_bytes);
		compare_field("upper_payload_len", got.upper_payload_len, want.upper_payload_len);
		compare_field("parse_status", got.parse_status, want.parse_status);
		n_status[want.parse_status]++;
		n_checked++;
	endtask

	// Everything is sampled at the falling edge, where inputs and outputs are
	// stable; a request or pop seen here is taken at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && pop && !empty)
			check_summary(result);
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("ipv6_header_chain_parser_top_tb NOT OK");
			$finish;
		end
	end

	// receiver: segments of steady pop, random pop and stall, plus long holds
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_kind = $urandom_range(0, 2);
				seg_left = $urandom_range(1, 30);
			end
			seg_left--;
			case (seg_kind)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom);
				default: pop <= 1'b0;
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic lst);
		result_t s;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		request <= '{data_byte: d, last_byte: lst};
		do @(negedge clk); while (full);
		@(posedge clk);
		n_bytes++;
		if (parse_byte(d, lst, s))
			pending_summaries.push_back(s);
	endtask

	task automatic send_packet();
		foreach (pkt[i])
			send_byte(pkt[i], i == pkt.size() - 1);
		n_packets++;
	endtask

	task automatic put_header(input int plen, input logic [7:0] nh, input logic [7:0] hop,
			input int fill);
		pkt.delete();
		repeat (4) pkt.push_back(8'($urandom));
		pkt.push_back(8'(plen >> 8));
		pkt.push_back(8'(plen));
		pkt.push_back(nh);
		pkt.push_back(hop);
		repeat (32)
			pkt.push_back(fill == FILL_ZEROS ? 8'h00 : fill == FILL_ONES ? 8'hFF :
				8'($urandom));
	endtask

	task automatic put_ext(input logic [7:0] next, input int len);
		pkt.push_back(next);
		pkt.push_back(8'(len));
		repeat ((len + 1) * 8 - 2) pkt.push_back(8'($urandom));
	endtask

	task automatic put_payload(input int n);
		repeat (n) pkt.push_back(8'($urandom));
	endtask

	task automatic set_payload_len(input int plen);
		pkt[4] = 8'(plen >> 8);
		pkt[5] = 8'(plen);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		burst_left = 0;
		while (pending_summaries.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_ext();
		case ($urandom_range(0, 5))
			0: return NH_HOPOPT;
			1: return NH_ROUTING;
			2: return NH_ESP;
			3: return NH_AH;
			4: return NH_DSTOPT;
			default: return NH_MOBILITY;
		endcase
	endfunction

	function automatic logic [7:0] pick_end();
		case ($urandom_range(0, 4))
			0: return NH_FRAGMENT;
			1: return NH_NO_NEXT;
			2: return NH_TCP;
			3: return NH_UDP;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic build_random_packet();
		int kind;
		int n_ext;
		int len;
		int plen;
		int cut;
		logic [7:0] code;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			pkt.delete();
			put_payload($urandom_range(1, 50));
			return;
		end
		n_ext = $urandom_range(0, 4);
		put_header(0, (n_ext > 0) ? pick_ext() : pick_end(), 8'($urandom),
			($urandom_range(0, 7) == 0) ? $urandom_range(FILL_ZEROS, FILL_ONES) : FILL_RANDOM);
		for (int i = 0; i < n_ext; i++) begin
			code = (i == n_ext - 1) ? pick_end() : pick_ext();
			len = ($urandom_range(0, 40) == 0) ? $urandom_range(3, 15) : $urandom_range(0, 2);
			put_ext(code, len);
		end
		put_payload($urandom_range(0, 24));
		plen = pkt.size() - FixedLen;
		case (kind)
			6: plen = $urandom_range(0, 65535);
			7: plen += $urandom_range(1, 16);
			8: put_payload($urandom_range(1, 12));
			9: if (pkt.size() > FixedLen) begin
				// cut after the fixed header and declare only what is left, so a header may overrun it
				cut = $urandom_range(FixedLen, pkt.size() - 1);
				while (pkt.size() > cut) void'(pkt.pop_back());
				plen = cut - FixedLen;
			end
			default: ;
		endcase
		set_payload_len(plen);
	endtask

	task automatic test_short_packets();
		pkt = {8'hFF};
		send_packet();
		pkt = {8'h00, 8'h00, 8'h00};
		send_packet();
	endtask

	task automatic test_plain_header();
		put_header(0, NH_NO_NEXT, 8'hFF, FILL_ONES);
		send_packet();
		put_header(3, NH_UDP, 8'h00, FILL_ZEROS);
		put_payload(3);
		send_packet();
	endtask

	task automatic test_extension_chain();
		put_header(0, NH_HOPOPT, 8'h40, FILL_RANDOM);
		put_ext(NH_ROUTING, 0);
		put_ext(NH_ESP, 0);
		put_ext(NH_AH, 1);
		put_ext(NH_DSTOPT, 0);
		put_ext(NH_MOBILITY, 0);
		put_ext(NH_FRAGMENT, 0);
		put_payload(5);
		set_payload_len(pkt.size() - FixedLen);
		send_packet();
		// widest extension length, cut short by the declared length
		put_header(0, NH_DSTOPT, 8'h01, FILL_RANDOM);
		pkt.push_back(NH_TCP);
		pkt.push_back(8'd255);
		put_payload(8);
		set_payload_len(pkt.size() - FixedLen);
		send_packet();
	endtask

	task automatic test_truncated_ext();
		// header extent ends past the declared length
		put_header(10, NH_ROUTING, 8'h20, FILL_RANDOM);
		put_payload(10);
		pkt[FixedLen] = NH_TCP;
		pkt[FixedLen + 1] = 8'd3;
		send_packet();
		// only the next-code byte lies inside the declared length
		put_header(1, NH_DSTOPT, 8'h20, FILL_RANDOM);
		put_payload(1);
		send_packet();
		// chain announced but no bytes after the fixed header
		put_header(0, NH_HOPOPT, 8'h20, FILL_RANDOM);
		send_packet();
	endtask

	task automatic test_trailing_bytes();
		put_header(2, NH_TCP, 8'h80, FILL_RANDOM);
		put_payload(12);
		send_packet();
		// extension lookalike after the declared end must be ignored
		put_header(8, NH_AH, 8'h80, FILL_RANDOM);
		put_ext(NH_ROUTING, 0);
		put_ext(NH_UDP, 1);
		send_packet();
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (30) begin
			pkt.delete();
			put_payload($urandom_range(1, 3));
			send_packet();
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		wait_drained();
		repeat ($urandom_range(20, 60)) @(posedge clk);
		put_header(0, NH_NO_NEXT, 8'h11, FILL_RANDOM);
		send_packet();
	endtask

	task automatic test_random_packets();
		int first_byte;
		first_byte = n_bytes;
		while (n_bytes - first_byte < RANDOM_BYTES) begin
			build_random_packet();
			send_packet();
		end
	endtask

	initial begin
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_packets();
		test_plain_header();
		test_extension_chain();
		test_truncated_ext();
		test_trailing_bytes();
		test_backpressure();
		test_drain_pause();
		test_random_packets();
		wait_drained();
		repeat (10) @(posedge clk);
		if (pending_summaries.size() != 0)
			report_error($sformatf("%0d summaries never arrived", pending_summaries.size()));
		$display("sent %0d bytes in %0d packets, checked %0d summaries", n_bytes, n_packets,
			n_checked);
		$display("status ok %0d, short %0d, truncated %0d; %0d errors",
			n_status[ST_OK], n_status[ST_SHORT], n_status[ST_TRUNC], errors);
		if (errors == 0)
			$display("ipv6_header_chain_parser_top_tb OK");
		else
			$display("ipv6_header_chain_parser_top_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
design/ihcp_pkg.sv
design/ihcp_front.sv
design/ihcp_fifo.sv
design/ihcp_back.sv
design/ipv6_header_chain_parser_top.sv
tb/sv/ipv6_header_chain_parser_top_tb.sv
